/* rtl/sha256_stream_hasher_assert.svh */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Concurrent check macros used by the hasher top module; they compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 hasher check failed");

`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 hasher check failed");

`else

`define SHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/shash_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Constants, control types and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package shash_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int BLK_W       = BLOCK_WORDS * WORD_W;
    localparam int FILL_W      = 6;
    localparam int RCNT_W      = 6;
    localparam int LEN_W       = 64;
    localparam int DIDX_W      = 3;
    localparam int OUT_DATA_W  = 40;

    localparam logic              CMD_ABSORB     = 1'b0;
    localparam logic              CMD_FINISH     = 1'b1;
    localparam logic [7:0]        PAD_BYTE       = 8'h80;
    localparam logic [7:0]        ZERO_BYTE      = 8'h00;
    localparam logic [FILL_W-1:0] LEN_FIRST_BYTE = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST      = 6'd63;
    localparam logic [RCNT_W-1:0] ROUND_LAST     = 6'd63;
    localparam logic [DIDX_W-1:0] DIDX_LAST      = 3'd7;
    localparam logic [LEN_W-1:0]  BYTE_BITS      = 64'd8;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t IV_WORDS [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RND_HOLD,
        RND_INIT,
        RND_STEP,
        RND_FOLD,
        RND_LOAD_IV
    } rnd_op_t;

    typedef struct packed {
        rnd_op_t           op;
        logic [RCNT_W-1:0] round_idx;
    } rnd_ctl_t;

    typedef enum logic [1:0] {
        SCH_HOLD,
        SCH_BYTE,
        SCH_WORD
    } sch_op_t;

    typedef struct packed {
        sch_op_t    op;
        logic [7:0] data;
    } sch_ctl_t;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

/* rtl/sha256_stream_hasher.sv */
// An absorb item is accepted as soon as it is valid while the current 64-byte
// block is not yet full; the item that completes a block holds the input off
// while the single round unit runs its 64 rounds and then the fold. A finish
// item writes the pad and length one byte per cycle up to the end of the
// block, compresses one block (two when fewer than 8 bytes of room remain
// after the pad byte, with a whole pad block between them), and then presents
// the eight digest words one per cycle, slower if the output side stalls.
// The last digest word may still wait in the output register while the next
// message is being absorbed.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with a shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [shash_pkg::OUT_DATA_W-1:0] m_tdata, // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    shash_pkg::state_t                  state_reg, state_next;
    logic [shash_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [shash_pkg::LEN_W-1:0]        bits_reg, bits_next;
    logic [shash_pkg::RCNT_W-1:0]       rcnt_reg, rcnt_next;
    logic [shash_pkg::DIDX_W-1:0]       ocnt_reg, ocnt_next;
    logic                               finishing_reg, finishing_next;
    logic                               final_blk_reg, final_blk_next;
    logic                               m_valid_reg, m_valid_next;
    shash_pkg::word_t                   out_word_reg, out_word_next;
    logic [shash_pkg::DIDX_W-1:0]       out_idx_reg, out_idx_next;
    logic                               out_last_reg, out_last_next;

    shash_pkg::sch_ctl_t                sch_ctl;
    shash_pkg::rnd_ctl_t                rnd_ctl;
    shash_pkg::word_t                   w_cur;
    shash_pkg::word_t                   digest [8];
    logic [shash_pkg::LEN_W-1:0]        len_shift;
    logic [7:0]                         len_byte;

    shash_sched u_sched (
        .aclk  (aclk),
        .ctl   (sch_ctl),
        .w_cur (w_cur)
    );

    shash_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rnd_ctl),
        .w_cur   (w_cur),
        .digest  (digest)
    );

    // Length bytes go out most significant first at block bytes 56 to 63.
    assign len_shift = bits_reg >> {~fill_reg[2:0], 3'b000};
    assign len_byte  = len_shift[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= shash_pkg::ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rcnt_reg      <= '0;
            ocnt_reg      <= '0;
            finishing_reg <= 1'b0;
            final_blk_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            rcnt_reg      <= rcnt_next;
            ocnt_reg      <= ocnt_next;
            finishing_reg <= finishing_next;
            final_blk_reg <= final_blk_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        rcnt_next      = rcnt_reg;
        ocnt_next      = ocnt_reg;
        finishing_next = finishing_reg;
        final_blk_next = final_blk_reg;
        m_valid_next   = m_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        sch_ctl        = '{op: shash_pkg::SCH_HOLD, data: shash_pkg::ZERO_BYTE};
        rnd_ctl        = '{op: shash_pkg::RND_HOLD, round_idx: rcnt_reg};
        s_tready       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            shash_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sch_ctl.op = shash_pkg::SCH_BYTE;
                    fill_next  = fill_reg + 6'd1;
                    if (s_tuser == shash_pkg::CMD_FINISH) begin
                        sch_ctl.data   = shash_pkg::PAD_BYTE;
                        finishing_next = 1'b1;
                        final_blk_next = (fill_reg < shash_pkg::LEN_FIRST_BYTE);
                    end else begin
                        sch_ctl.data = s_tdata;
                        bits_next    = bits_reg + shash_pkg::BYTE_BITS;
                    end
                    if (fill_reg == shash_pkg::FILL_LAST) begin
                        rnd_ctl.op = shash_pkg::RND_INIT;
                        rcnt_next  = '0;
                        state_next = shash_pkg::ST_ROUND;
                    end else if (s_tuser == shash_pkg::CMD_FINISH) begin
                        state_next = shash_pkg::ST_PAD;
                    end
                end
            end
            shash_pkg::ST_PAD: begin
                sch_ctl.op = shash_pkg::SCH_BYTE;
                if (final_blk_reg && (fill_reg >= shash_pkg::LEN_FIRST_BYTE)) begin
                    sch_ctl.data = len_byte;
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == shash_pkg::FILL_LAST) begin
                    rnd_ctl.op = shash_pkg::RND_INIT;
                    rcnt_next  = '0;
                    state_next = shash_pkg::ST_ROUND;
                end
            end
            shash_pkg::ST_ROUND: begin
                rnd_ctl.op = shash_pkg::RND_STEP;
                sch_ctl.op = shash_pkg::SCH_WORD;
                rcnt_next  = rcnt_reg + 6'd1;
                if (rcnt_reg == shash_pkg::ROUND_LAST) begin
                    state_next = shash_pkg::ST_FOLD;
                end
            end
            shash_pkg::ST_FOLD: begin
                rnd_ctl.op = shash_pkg::RND_FOLD;
                if (!finishing_reg) begin
                    state_next = shash_pkg::ST_IDLE;
                end else if (final_blk_reg) begin
                    ocnt_next  = '0;
                    state_next = shash_pkg::ST_EMIT;
                end else begin
                    final_blk_next = 1'b1;
                    state_next     = shash_pkg::ST_PAD;
                end
            end
            shash_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_word_next = digest[ocnt_reg];
                    out_idx_next  = ocnt_reg;
                    out_last_next = (ocnt_reg == shash_pkg::DIDX_LAST);
                    ocnt_next     = ocnt_reg + 3'd1;
                    if (ocnt_reg == shash_pkg::DIDX_LAST) begin
                        rnd_ctl.op     = shash_pkg::RND_LOAD_IV;
                        fill_next      = '0;
                        bits_next      = '0;
                        finishing_next = 1'b0;
                        final_blk_next = 1'b0;
                        state_next     = shash_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = shash_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, out_idx_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    `SHS_ASSERT_NEXT(a_round_to_fold, aclk, aresetn, (state_reg == shash_pkg::ST_ROUND) && (rcnt_reg == shash_pkg::ROUND_LAST), state_reg == shash_pkg::ST_FOLD)
    `SHS_ASSERT_NOW(a_round_block_full, aclk, aresetn, (state_reg == shash_pkg::ST_ROUND) || (state_reg == shash_pkg::ST_FOLD), fill_reg == '0)
    `SHS_ASSERT_NOW(a_pad_finishing, aclk, aresetn, (state_reg == shash_pkg::ST_PAD) || (state_reg == shash_pkg::ST_EMIT), finishing_reg)
    `SHS_ASSERT_NEXT(a_finish_flag, aclk, aresetn, s_tvalid && s_tready && (s_tuser == shash_pkg::CMD_FINISH), finishing_reg)

endmodule

/* rtl/shash_sched.sv */
// ----------------------------------------------------------------------------
// SHA-256 block store and message schedule
// Bytes shift in big-endian to fill the 512-bit block; during compression the
// same register shifts by one word per round and appends the expanded word.
// ----------------------------------------------------------------------------
module shash_sched (
    input  logic                aclk,
    input  shash_pkg::sch_ctl_t ctl,
    output shash_pkg::word_t    w_cur
);

    logic [shash_pkg::BLK_W-1:0] blk_reg;
    logic [shash_pkg::BLK_W-1:0] blk_next;
    shash_pkg::word_t            w_new;

    always_comb begin
        w_new = blk_reg[511:480]
              + shash_pkg::small_sigma0(blk_reg[479:448])
              + blk_reg[223:192]
              + shash_pkg::small_sigma1(blk_reg[63:32]);
    end

    always_comb begin
        unique case (ctl.op)
            shash_pkg::SCH_BYTE: begin
                blk_next = {blk_reg[shash_pkg::BLK_W-9:0], ctl.data};
            end
            shash_pkg::SCH_WORD: begin
                blk_next = {blk_reg[shash_pkg::BLK_W-shash_pkg::WORD_W-1:0], w_new};
            end
            default: begin
                blk_next = blk_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

    assign w_cur = blk_reg[511:480];

endmodule

/* rtl/shash_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the chaining words and the working variables; performs one
// compression round per step and folds the result into the chain.
// ----------------------------------------------------------------------------
module shash_round (
    input  logic                aclk,
    input  logic                aresetn,
    input  shash_pkg::rnd_ctl_t ctl,
    input  shash_pkg::word_t    w_cur,
    output shash_pkg::word_t    digest [8]
);

    shash_pkg::word_t chain_reg [8];
    shash_pkg::word_t chain_next [8];
    shash_pkg::word_t work_reg [8];
    shash_pkg::word_t work_next [8];
    shash_pkg::word_t t1;
    shash_pkg::word_t t2;

    always_comb begin
        t1 = work_reg[7] + shash_pkg::big_sigma1(work_reg[4])
           + shash_pkg::choose(work_reg[4], work_reg[5], work_reg[6])
           + shash_pkg::ROUND_K[ctl.round_idx] + w_cur;
        t2 = shash_pkg::big_sigma0(work_reg[0])
           + shash_pkg::majority(work_reg[0], work_reg[1], work_reg[2]);
        chain_next = chain_reg;
        work_next  = work_reg;
        unique case (ctl.op)
            shash_pkg::RND_INIT: begin
                work_next = chain_reg;
            end
            shash_pkg::RND_STEP: begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
            end
            shash_pkg::RND_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
            shash_pkg::RND_LOAD_IV: begin
                chain_next = shash_pkg::IV_WORDS;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= shash_pkg::IV_WORDS;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign digest = chain_reg;

endmodule

/* test/sha256_stream_hasher_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte messages into the hasher and checks every digest word against
// a SHA-256 predictor that is updated on each accepted item. It covers short
// known messages, messages that end at and around the padding boundary, and
// random messages under several flow-control mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 70;
    localparam int HOLD_CYCLES  = 1500;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [5:0]   fill_bytes;
    logic [63:0]  msg_bit_len;
    digest_item_t digest_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len_req   = 0;
    int hold_left      = 0;
    logic hold_tog     = 1'b0;
    logic hold_seen    = 1'b0;

    int cycle_cnt      = 0;
    int mismatches     = 0;
    int items_accepted = 0;
    int messages_done  = 0;
    int two_block_pads = 0;
    int blocks_folded  = 0;
    int words_checked  = 0;

    sha256_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void rearm_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = HASH_INIT[i];
        for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
        fill_bytes  = '0;
        msg_bit_len = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
        blocks_folded++;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        msg_block[fill_bytes[5:2]][(3 - fill_bytes[1:0]) * 8 +: 8] = b;
        msg_bit_len += 64'd8;
        fill_bytes  += 6'd1;
        if (fill_bytes == 6'd0) sha_compress();
    endfunction

    function automatic void finish_message();
        digest_item_t item;
        msg_block[fill_bytes[5:2]][(3 - fill_bytes[1:0]) * 8 +: 8] = 8'h80;
        // With fewer than eight bytes of room after the pad byte the length goes into an extra block.
        if (fill_bytes >= 6'd56) begin
            sha_compress();
            two_block_pads++;
        end
        msg_block[14] = msg_bit_len[63:32];
        msg_block[15] = msg_bit_len[31:0];
        sha_compress();
        for (int i = 0; i < 8; i++) begin
            item.word  = hash_state[i];
            item.index = i[2:0];
            item.last  = (i == 7);
            digest_q.push_back(item);
        end
        rearm_hash();
        messages_done++;
    endfunction

    function automatic void check_digest_word();
        digest_item_t got;
        digest_item_t want;
        got.word  = m_tdata[31:0];
        got.index = m_tdata[34:32];
        got.last  = m_tlast;
        if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h index %0d last %b",
                         got.word, got.index, got.last);
        end else begin
            want = digest_q.pop_front();
            words_checked++;
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                             want.word, want.index, want.last, got.word, got.index, got.last);
            end
        end
    endfunction

    initial rearm_hash();

    // Output is checked before the input item of the same edge is predicted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_digest_word();
        if (aresetn && s_tvalid && s_tready) begin
            items_accepted++;
            if (s_tuser == shash_pkg::CMD_FINISH) finish_message();
            else absorb_byte(s_tdata);
        end
    end

    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= hold_len_req;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("sha256_stream_hasher test failed");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_item(shash_pkg::CMD_ABSORB, 8'($urandom_range(255)));
        send_item(shash_pkg::CMD_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic test_known_messages();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(shash_pkg::CMD_FINISH, 8'h00);
        send_item(shash_pkg::CMD_FINISH, 8'hFF);
        send_item(shash_pkg::CMD_ABSORB, 8'h61);
        send_item(shash_pkg::CMD_ABSORB, 8'h62);
        send_item(shash_pkg::CMD_ABSORB, 8'h63);
        send_item(shash_pkg::CMD_FINISH, 8'h00);
        send_item(shash_pkg::CMD_ABSORB, 8'h00);
        send_item(shash_pkg::CMD_FINISH, 8'hA5);
        send_item(shash_pkg::CMD_ABSORB, 8'hFF);
        send_item(shash_pkg::CMD_FINISH, 8'h5A);
        send_item(shash_pkg::CMD_ABSORB, 8'h55);
        send_item(shash_pkg::CMD_ABSORB, 8'hAA);
        send_item(shash_pkg::CMD_FINISH, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  len = 55; end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  len = 56; end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; len = 63; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; len = 64; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_message(len);
                sent += len + 1;
                len = ($urandom_range(7) == 0) ? $urandom_range(65, 130)
                                               : $urandom_range(0, 24);
            end
            wait_drained();
        end
    endtask

    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len_req <= HOLD_CYCLES;
        hold_tog     <= ~hold_tog;
        for (int m = 0; m < 5; m++) send_message($urandom_range(0, 6));
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_known_messages();
        test_random_messages();
        test_output_hold_off();
        if (digest_q.size() != 0) mismatches += digest_q.size();
        $display("Hashed %0d messages from %0d items, folding %0d blocks (%0d with a spill pad block).",
                 messages_done, items_accepted, blocks_folded, two_block_pads);
        $display("Checked %0d digest words under four flow-control mixes and a long output hold-off.",
                 words_checked);
        if (mismatches == 0) begin
            $display("sha256_stream_hasher test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sha256_stream_hasher test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/shash_pkg.sv
rtl/shash_sched.sv
rtl/shash_round.sv
rtl/sha256_stream_hasher.sv
test/sha256_stream_hasher_test.sv
